// ===== hdl/tcc_pkg.sv =====
// Shared widths, latencies and types of the tetrahedron circumcenter pipeline.
package tcc_pkg;

  localparam int CW        = 32;
  localparam int EW        = CW + 1;
  localparam int XW        = 2 * EW + 1;
  localparam int SW        = 2 * EW;
  localparam int LW        = 34;
  localparam int MW        = 2 * LW;
  localparam int RW        = 2 * MW;
  localparam int NW        = RW + 1;
  localparam int DW        = 102;
  localparam int QW        = CW + 1;
  localparam int SX        = CW + 3;
  localparam int FRONT_LAT = 8;
  localparam int LANE_LAT  = QW + 3;
  localparam int PIPE_LAT  = FRONT_LAT + LANE_LAT;
  localparam int IN_W      = 12 * CW;
  localparam int OUT_W     = 3 * CW;
  localparam int USER_W    = 2;
  localparam int USR_DEGEN = 0;
  localparam int USR_CLIP  = 1;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [MW-1:0] mul_in_t;
  typedef logic signed [RW-1:0] prod_t;

endpackage

// ===== hdl/tcc_mul.sv =====
// Four-stage signed multiplier built from four limb products.
module tcc_mul (
  input  logic            clk_i,
  input  logic            ce_i,
  input  tcc_pkg::mul_in_t a_i,
  input  tcc_pkg::mul_in_t b_i,
  output tcc_pkg::prod_t   p_o
);

  logic                         neg1_q, neg2_q, neg3_q;
  logic [tcc_pkg::MW-1:0]       am_q, bm_q;
  logic [tcc_pkg::MW-1:0]       pp_q [4];
  logic [tcc_pkg::RW-1:0]       sum_q;
  tcc_pkg::prod_t               p_q;

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      neg1_q   <= a_i[tcc_pkg::MW-1] ^ b_i[tcc_pkg::MW-1];
      am_q     <= a_i[tcc_pkg::MW-1] ? $unsigned(-a_i) : $unsigned(a_i);
      bm_q     <= b_i[tcc_pkg::MW-1] ? $unsigned(-b_i) : $unsigned(b_i);
      neg2_q   <= neg1_q;
      pp_q[0]  <= am_q[tcc_pkg::LW-1:0] * bm_q[tcc_pkg::LW-1:0];
      pp_q[1]  <= am_q[tcc_pkg::LW-1:0] * bm_q[tcc_pkg::MW-1:tcc_pkg::LW];
      pp_q[2]  <= am_q[tcc_pkg::MW-1:tcc_pkg::LW] * bm_q[tcc_pkg::LW-1:0];
      pp_q[3]  <= am_q[tcc_pkg::MW-1:tcc_pkg::LW] * bm_q[tcc_pkg::MW-1:tcc_pkg::LW];
      neg3_q   <= neg2_q;
      sum_q    <= tcc_pkg::RW'(pp_q[0])
                + (tcc_pkg::RW'(pp_q[1]) << tcc_pkg::LW)
                + (tcc_pkg::RW'(pp_q[2]) << tcc_pkg::LW)
                + (tcc_pkg::RW'(pp_q[3]) << tcc_pkg::MW);
      p_q      <= neg3_q ? -$signed(sum_q) : $signed(sum_q);
    end
  end

  assign p_o = p_q;

endmodule

// ===== hdl/tcc_div.sv =====
// One coordinate lane: rounded restoring division, offset by d and saturation.
module tcc_div (
  input  logic             clk_i,
  input  logic             ce_i,
  input  tcc_pkg::prod_t   num_i,
  input  tcc_pkg::prod_t   den_i,
  input  tcc_pkg::coord_t  d_i,
  output tcc_pkg::coord_t  coord_o,
  output logic             clip_o
);

  localparam int QW = tcc_pkg::QW;
  localparam int DW = tcc_pkg::DW;
  localparam int NW = tcc_pkg::NW;
  localparam int RW = tcc_pkg::RW;
  localparam int CW = tcc_pkg::CW;
  localparam int SX = tcc_pkg::SX;

  tcc_pkg::prod_t    den2;
  logic [RW-1:0]     dmag;
  logic [RW-1:0]     nmag;

  logic [NW-1:0]     n0_q;
  logic [DW-1:0]     dv0_q;
  logic              neg0_q;
  tcc_pkg::coord_t   d0_q;

  logic [DW-1:0]     rem_q  [QW+1];
  logic [QW-1:0]     nl_q   [QW+1];
  logic [QW-1:0]     qt_q   [QW+1];
  logic [DW-1:0]     dv_q   [QW+1];
  logic              neg_q  [QW+1];
  logic              huge_q [QW+1];
  tcc_pkg::coord_t   d_q    [QW+1];

  logic signed [SX-1:0] sum;
  tcc_pkg::coord_t   coord_q;
  logic              clip_q;

  always_comb begin
    den2 = den_i <<< 1;
    dmag = den2[RW-1] ? $unsigned(-den2) : $unsigned(den2);
    nmag = num_i[RW-1] ? $unsigned(-num_i) : $unsigned(num_i);
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      n0_q      <= {nmag, 1'b0} + NW'(dmag);
      dv0_q     <= {dmag[DW-2:0], 1'b0};
      neg0_q    <= num_i[RW-1] ^ den_i[RW-1];
      d0_q      <= d_i;
      huge_q[0] <= n0_q >= (NW'(dv0_q) << QW);
      rem_q[0]  <= n0_q[QW +: DW];
      nl_q[0]   <= n0_q[QW-1:0];
      qt_q[0]   <= '0;
      dv_q[0]   <= dv0_q;
      neg_q[0]  <= neg0_q;
      d_q[0]    <= d0_q;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int K = QW - 1 - j;
    logic [DW:0]   r2;
    logic          ge;
    logic [QW-1:0] qn;

    always_comb begin
      r2    = {rem_q[j], nl_q[j][K]};
      ge    = r2 >= {1'b0, dv_q[j]};
      qn    = qt_q[j];
      qn[K] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        rem_q[j+1]  <= ge ? DW'(r2 - {1'b0, dv_q[j]}) : DW'(r2);
        qt_q[j+1]   <= qn;
        nl_q[j+1]   <= nl_q[j];
        dv_q[j+1]   <= dv_q[j];
        neg_q[j+1]  <= neg_q[j];
        huge_q[j+1] <= huge_q[j];
        d_q[j+1]    <= d_q[j];
      end
    end
  end

  always_comb begin
    if (neg_q[QW]) begin
      sum = SX'(d_q[QW]) - $signed(SX'(qt_q[QW]));
    end else begin
      sum = SX'(d_q[QW]) + $signed(SX'(qt_q[QW]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      if (huge_q[QW]) begin
        coord_q <= neg_q[QW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        clip_q  <= 1'b1;
      end else if (sum[SX-1:CW-1] != {(SX-CW+1){sum[SX-1]}}) begin
        coord_q <= sum[SX-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        clip_q  <= 1'b1;
      end else begin
        coord_q <= sum[CW-1:0];
        clip_q  <= 1'b0;
      end
    end
  end

  assign coord_o = coord_q;
  assign clip_o  = clip_q;

endmodule

// ===== hdl/tetrahedron_circumcenter.sv =====
// Top level of the pipelined tetrahedron circumcenter unit.
// The slave stream carries one tetrahedron per request: twelve signed Q16.16
// coordinates a, b, c, d packed in s_axis_tdata. The master stream returns
// the circumcenter in m_axis_tdata with the degenerate and clipped flags in
// m_axis_tuser. A new tetrahedron is accepted in every cycle while
// s_axis_tready is high, so throughput is one request per clock unless the
// skid register is full. A result passes through eight front stages for edge
// vectors, cross products and four-stage limb multipliers, then 36 stages per
// coordinate lane whose 33-step restoring divider sets the depth, then the
// output register. A flat tetrahedron returns center zero with the degenerate
// flag set. Reset clears all valid bits, including those of the output and
// skid registers.
// When the receiver stalls, the result in flight parks in a skid register
// and the whole pipeline holds; s_axis_tready falls only while that skid
// register is full, and nothing is lost or repeated.
module tetrahedron_circumcenter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z.
  input  logic [tcc_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: center_x, center_y, center_z.
  output logic [tcc_pkg::OUT_W-1:0]     m_axis_tdata,
  // Fields from bit 0: degenerate, clipped.
  output logic [tcc_pkg::USER_W-1:0]    m_axis_tuser
);

  localparam int CW  = tcc_pkg::CW;
  localparam int EW  = tcc_pkg::EW;
  localparam int SW  = tcc_pkg::SW;
  localparam int XW  = tcc_pkg::XW;
  localparam int MW  = tcc_pkg::MW;
  localparam int FL  = tcc_pkg::FRONT_LAT;
  localparam int LL  = tcc_pkg::LANE_LAT;
  localparam int PL  = tcc_pkg::PIPE_LAT;

  logic                    ce;
  tcc_pkg::coord_t         vin   [4][3];
  logic signed [EW-1:0]    e1_q  [3][3];
  logic signed [SW-1:0]    pa_q  [3][3];
  logic signed [SW-1:0]    pb_q  [3][3];
  logic signed [SW-1:0]    sq_q  [3][3];
  logic signed [EW-1:0]    t2_q  [3];
  logic signed [XW-1:0]    x3_q  [3][3];
  logic [SW-1:0]           nrm3_q[3];
  logic signed [EW-1:0]    t3_q  [3];
  tcc_pkg::prod_t          pden  [3];
  tcc_pkg::prod_t          pnum  [3][3];
  tcc_pkg::prod_t          den8_q;
  tcc_pkg::prod_t          num8_q[3];
  tcc_pkg::coord_t         dly_q [FL][3];
  tcc_pkg::coord_t         lane_c[3];
  logic [2:0]              lane_clip;
  logic [PL-1:0]           vld_q;
  logic [LL-1:0]           deg_q;

  logic                        r_v;
  logic [tcc_pkg::OUT_W-1:0]   r_data;
  logic [tcc_pkg::USER_W-1:0]  r_user;
  logic                        out_v_q, skid_v_q;
  logic [tcc_pkg::OUT_W-1:0]   out_data_q, skid_data_q;
  logic [tcc_pkg::USER_W-1:0]  out_user_q, skid_user_q;
  logic                        out_take;

  assign ce = !skid_v_q;

  for (genvar k = 0; k < 4; k++) begin : g_vin
    for (genvar i = 0; i < 3; i++) begin : g_axis
      assign vin[k][i] = s_axis_tdata[(3*k+i)*CW +: CW];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_edge
    for (genvar i = 0; i < 3; i++) begin : g_axis
      localparam int P  = (c + 1) % 3;
      localparam int Q  = (c + 2) % 3;
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      always_ff @(posedge clk_i) begin
        if (ce) begin
          e1_q[c][i] <= EW'(vin[c][i]) - EW'(vin[3][i]);
          pa_q[c][i] <= SW'(e1_q[P][I1]) * SW'(e1_q[Q][I2]);
          pb_q[c][i] <= SW'(e1_q[P][I2]) * SW'(e1_q[Q][I1]);
          sq_q[c][i] <= SW'(e1_q[c][i]) * SW'(e1_q[c][i]);
          x3_q[c][i] <= XW'(pa_q[c][i]) - XW'(pb_q[c][i]);
        end
      end

      tcc_mul u_mul_num (
        .clk_i (clk_i),
        .ce_i  (ce),
        .a_i   ($signed(MW'(nrm3_q[c]))),
        .b_i   (MW'(x3_q[c][i])),
        .p_o   (pnum[c][i])
      );
    end

    always_ff @(posedge clk_i) begin
      if (ce) begin
        t2_q[c]   <= e1_q[0][c];
        t3_q[c]   <= t2_q[c];
        nrm3_q[c] <= $unsigned(sq_q[c][0]) + $unsigned(sq_q[c][1]) + $unsigned(sq_q[c][2]);
        num8_q[c] <= pnum[0][c] + pnum[1][c] + pnum[2][c];
      end
    end

    tcc_mul u_mul_den (
      .clk_i (clk_i),
      .ce_i  (ce),
      .a_i   (MW'(t3_q[c])),
      .b_i   (MW'(x3_q[0][c])),
      .p_o   (pden[c])
    );

    tcc_div u_lane (
      .clk_i   (clk_i),
      .ce_i    (ce),
      .num_i   (num8_q[c]),
      .den_i   (den8_q),
      .d_i     (dly_q[FL-1][c]),
      .coord_o (lane_c[c]),
      .clip_o  (lane_clip[c])
    );

    always_ff @(posedge clk_i) begin
      if (ce) begin
        dly_q[0][c] <= vin[3][c];
      end
    end
    for (genvar s = 1; s < FL; s++) begin : g_dly
      always_ff @(posedge clk_i) begin
        if (ce) begin
          dly_q[s][c] <= dly_q[s-1][c];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      den8_q <= pden[0] + pden[1] + pden[2];
      deg_q  <= {deg_q[LL-2:0], den8_q == '0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[PL-2:0], s_axis_tvalid};
    end
  end

  always_comb begin
    r_v = vld_q[PL-1];
    if (deg_q[LL-1]) begin
      r_data = '0;
      r_user = '0;
      r_user[tcc_pkg::USR_DEGEN] = 1'b1;
    end else begin
      r_data = {lane_c[2], lane_c[1], lane_c[0]};
      r_user = '0;
      r_user[tcc_pkg::USR_CLIP] = |lane_clip;
    end
  end

  assign out_take = out_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_take) begin
        skid_v_q <= 1'b0;
      end
    end else if (r_v) begin
      if (out_v_q && !out_take) begin
        skid_v_q <= 1'b1;
      end
      out_v_q <= 1'b1;
    end else if (out_take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_take) begin
        out_data_q <= skid_data_q;
        out_user_q <= skid_user_q;
      end
    end else if (r_v) begin
      if (out_v_q && !out_take) begin
        skid_data_q <= r_data;
        skid_user_q <= r_user;
      end else begin
        out_data_q <= r_data;
        out_user_q <= r_user;
      end
    end
  end

  assign s_axis_tready = ce;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result while the output register is empty");

  a_stall_keeps_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !m_axis_tready |=> out_v_q)
    else $error("stalled result dropped from the output register");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready && r_v))
    else $error("skid register filled without a stalled output");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_user_q[tcc_pkg::USR_DEGEN]
      |-> !out_user_q[tcc_pkg::USR_CLIP] && out_data_q == '0)
    else $error("degenerate result carries a nonzero center or clip flag");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench of the tetrahedron circumcenter stream unit.
module tb;

  typedef logic [11:0][tcc_pkg::CW-1:0] tetra_t;
  typedef logic signed [255:0] wide_t;
  typedef struct packed {
    logic [tcc_pkg::OUT_W-1:0]  center;
    logic [tcc_pkg::USER_W-1:0] flags;
  } circ_t;
  typedef struct {
    tetra_t pts;
    bit     known;
    circ_t  res;
  } row_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;
  localparam logic signed [tcc_pkg::CW-1:0] ONE = 32'sh0001_0000;
  localparam logic signed [tcc_pkg::CW-1:0] MAXC = 32'sh7fff_ffff;
  localparam logic signed [tcc_pkg::CW-1:0] MINC = 32'sh8000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [tcc_pkg::IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [tcc_pkg::OUT_W-1:0] m_axis_tdata;
  logic [tcc_pkg::USER_W-1:0] m_axis_tuser;

  circ_t circ_q[$];
  row_t  rows[$];
  int    n_err = 0;
  int    n_sent = 0;
  int    n_recv = 0;
  int    n_degen = 0;
  int    n_clip = 0;
  int    idle_cnt = 0;
  bit    idle_on = 1'b1;
  bit    hold_req = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tetrahedron_circumcenter i_dut (.*);

  function automatic wide_t wabs(wide_t x);
    return (x < 0) ? -x : x;
  endfunction

  // Exact circumcenter with rounding to nearest, ties away from zero.
  function automatic circ_t circumcenter(tetra_t p);
    wide_t t[3], u[3], v[3], uv[3], vt[3], tu[3], dv[3];
    wide_t det2, dmag, nt, nu, nv, num, q, s;
    circ_t r;
    bit    neg, clip;
    clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dv[i] = wide_t'(tcc_pkg::coord_t'(p[9+i]));
      t[i]  = wide_t'(tcc_pkg::coord_t'(p[i])) - dv[i];
      u[i]  = wide_t'(tcc_pkg::coord_t'(p[3+i])) - dv[i];
      v[i]  = wide_t'(tcc_pkg::coord_t'(p[6+i])) - dv[i];
    end
    for (int i = 0; i < 3; i++) begin
      uv[i] = u[(i+1)%3] * v[(i+2)%3] - u[(i+2)%3] * v[(i+1)%3];
      vt[i] = v[(i+1)%3] * t[(i+2)%3] - v[(i+2)%3] * t[(i+1)%3];
      tu[i] = t[(i+1)%3] * u[(i+2)%3] - t[(i+2)%3] * u[(i+1)%3];
    end
    det2 = 2 * (t[0] * uv[0] + t[1] * uv[1] + t[2] * uv[2]);
    r = '0;
    if (det2 == 0) begin
      r.flags[tcc_pkg::USR_DEGEN] = 1'b1;
      return r;
    end
    dmag = wabs(det2);
    nt = t[0] * t[0] + t[1] * t[1] + t[2] * t[2];
    nu = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
    nv = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    for (int i = 0; i < 3; i++) begin
      num = nt * uv[i] + nu * vt[i] + nv * tu[i];
      neg = (num < 0) != (det2 < 0);
      q = wide_t'($unsigned(2 * wabs(num) + dmag) / $unsigned(2 * dmag));
      if (q >= (wide_t'(1) <<< 33)) s = neg ? -(wide_t'(1) <<< 32) : (wide_t'(1) <<< 32);
      else s = neg ? dv[i] - q : dv[i] + q;
      if (s > wide_t'(MAXC)) begin
        s = wide_t'(MAXC);
        clip = 1'b1;
      end
      if (s < wide_t'(MINC)) begin
        s = wide_t'(MINC);
        clip = 1'b1;
      end
      r.center[i*tcc_pkg::CW +: tcc_pkg::CW] = s[tcc_pkg::CW-1:0];
    end
    r.flags[tcc_pkg::USR_CLIP] = clip;
    return r;
  endfunction

  task automatic report(string what, logic [127:0] got, logic [127:0] want);
    n_err++;
    $display("mismatch %s at result %0d: got %h want %h", what, n_recv, got, want);
  endtask

  function automatic tetra_t mk(tcc_pkg::coord_t ax, tcc_pkg::coord_t ay, tcc_pkg::coord_t az,
                                tcc_pkg::coord_t bx, tcc_pkg::coord_t by, tcc_pkg::coord_t bz,
                                tcc_pkg::coord_t cx, tcc_pkg::coord_t cy, tcc_pkg::coord_t cz,
                                tcc_pkg::coord_t dx, tcc_pkg::coord_t dy, tcc_pkg::coord_t dz);
    return {dz, dy, dx, cz, cy, cx, bz, by, bx, az, ay, ax};
  endfunction

  function automatic tetra_t rand_tetra();
    tetra_t p;
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 12; k++) p[k] = $urandom;
    if (kind inside {[4:6]}) begin
      for (int k = 0; k < 9; k++)
        p[k] = p[9 + k%3]
             + tcc_pkg::coord_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    end else if (kind == 7) begin
      for (int k = 0; k < 3; k++) p[3+k] = p[k];
    end else if (kind >= 8) begin
      for (int k = 0; k < 3; k++) begin
        p[9+k] = p[9+k] >>> 4;
        p[k] = p[9+k] + tcc_pkg::coord_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        p[3+k] = p[9+k] + tcc_pkg::coord_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        p[6+k] = p[k] + p[3+k] - p[9+k];
      end
      if (kind == 8) p[6 + $urandom_range(0, 2)] += 1;
    end
    return p;
  endfunction

  task automatic add_row(tetra_t p, bit known = 1'b0, circ_t res = '0);
    row_t r;
    r.pts = p;
    r.known = known;
    r.res = res;
    rows = {rows, r};
  endtask

  task automatic send(tetra_t p);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= p;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) circ_q = {circ_q, circumcenter(s_axis_tdata)};
  end

  always @(posedge clk_i) begin
    circ_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (circ_q.size() == 0) begin
        report("unexpected result", {m_axis_tuser, m_axis_tdata}, '0);
      end else begin
        want = circ_q.pop_front();
        for (int i = 0; i < 3; i++)
          if (m_axis_tdata[i*tcc_pkg::CW +: tcc_pkg::CW]
              !== want.center[i*tcc_pkg::CW +: tcc_pkg::CW])
            report($sformatf("center[%0d]", i), m_axis_tdata[i*tcc_pkg::CW +: tcc_pkg::CW],
                   want.center[i*tcc_pkg::CW +: tcc_pkg::CW]);
        if (m_axis_tuser[tcc_pkg::USR_DEGEN] !== want.flags[tcc_pkg::USR_DEGEN])
          report("degenerate", m_axis_tuser[tcc_pkg::USR_DEGEN],
                 want.flags[tcc_pkg::USR_DEGEN]);
        if (m_axis_tuser[tcc_pkg::USR_CLIP] !== want.flags[tcc_pkg::USR_CLIP])
          report("clipped", m_axis_tuser[tcc_pkg::USR_CLIP], want.flags[tcc_pkg::USR_CLIP]);
        n_degen += want.flags[tcc_pkg::USR_DEGEN];
        n_clip += want.flags[tcc_pkg::USR_CLIP];
      end
      n_recv++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("FAIL tetrahedron_circumcenter");
      $finish;
    end
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = idle_on ? $urandom_range(0, 3) : 0;
      if (hold_req) begin
        stall = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    row_t r;
    circ_t half;
    tetra_t p;
    half.center = {3{32'sh0000_8000}};
    half.flags = '0;
    add_row('0, 1'b1, circ_t'(3'b0 | (1 << tcc_pkg::USR_DEGEN)));
    add_row({12{MAXC}}, 1'b1, circ_t'(1 << tcc_pkg::USR_DEGEN));
    add_row({12{MINC}}, 1'b1, circ_t'(1 << tcc_pkg::USR_DEGEN));
    add_row(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0), 1'b1, half);
    add_row(mk(ONE, ONE, 0, ONE, 0, ONE, 0, ONE, ONE, ONE, ONE, ONE));
    add_row(mk(MAXC, 0, 0, 0, MAXC, 0, 0, 0, MAXC, MINC, MINC, MINC));
    add_row(mk(MINC, MAXC, MINC, MAXC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC, MAXC));
    add_row(mk(MAXC, MAXC, MAXC, MINC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MINC));
    add_row(mk(1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0));
    add_row(mk(ONE, 0, 0, 0, ONE, 0, ONE, ONE, 1, 0, 0, 0));
    add_row(mk(ONE, 0, 0, 0, ONE, 0, ONE, ONE, 0, 0, 0, 0), 1'b1,
            circ_t'(1 << tcc_pkg::USR_DEGEN));
    add_row(mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE, 0, 0, 0));
    add_row(mk(3, -1, 0, 0, 2, -2, 1, 1, 1, -1, -1, -1));
    add_row(mk(MAXC, 0, 0, 0, 1, 0, MAXC, 1, 1, 0, 0, 0));
    add_row({32'hffff_ffff, 32'haaaa_aaaa, 32'h5555_5555, 32'h0123_4567, 32'h89ab_cdef,
             32'hfedc_ba98, 32'h7654_3210, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h3333_3333,
             32'hcccc_cccc, 32'h8000_0001});
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[k]) begin
      r = rows[k];
      if (r.known && circumcenter(r.pts) !== r.res)
        report("directed row", circumcenter(r.pts), r.res);
      send(r.pts);
    end
    for (int k = 0; k < 950; k++) begin
      if (k % 150 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (k == 300) hold_req = 1'b1;
      p = rand_tetra();
      send(p);
    end
    s_axis_tvalid <= 1'b0;
    while (circ_q.size() != 0) @(posedge clk_i);
    repeat (tcc_pkg::PIPE_LAT + 20) @(posedge clk_i);
    $display("Sent %0d tetrahedra and checked %0d centers (%0d flat, %0d saturated),",
             n_sent, n_recv, n_degen, n_clip);
    $display("with random stalls on both sides and one long output hold-off.");
    if (n_err == 0) begin
      $display("PASS tetrahedron_circumcenter");
    end else begin
      $display("FAIL tetrahedron_circumcenter");
    end
    $finish;
  end

endmodule
